[design/velocity_pi_with_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the velocity PI controller
// Concurrent check helpers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_PI_WITH_FILTER_TOP_MACROS_SVH
`define VELOCITY_PI_WITH_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpf assertion failed");

// next-cycle implication
`define VPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpf assertion failed");

`else

`define VPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VPF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/vpf_pkg.sv]
// ----------------------------------------------------------------------------
// vpf_pkg
// Types and constants shared by the velocity PI controller modules.
// ----------------------------------------------------------------------------
package vpf_pkg;

  localparam int MAC_A_W   = 32;
  localparam int MAC_B_W   = 22;
  localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
  localparam int FILT_W    = 26;
  localparam int INTEG_W   = 32;
  localparam int SUM_W     = 34;
  localparam int ACC_W     = 50;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 28;
  localparam int OFFSET_W  = 16;
  localparam int Q_W       = 17;
  localparam int X_W       = 20;
  localparam int X_SH      = 18;
  localparam int RECIP_SH  = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 28;

  localparam logic signed [MAC_B_W-1:0] FILT_KEEP = 22'sd215;
  localparam logic signed [MAC_B_W-1:0] ERR_GAIN  = 22'sd41;
  // ceil(2^25 / 25): exact quotient by 25 for magnitudes below 2^20
  localparam logic signed [MAC_A_W-1:0] DRIVE_RECIP = 32'sd1342178;

  localparam logic signed [FILT_W-1:0]  FILT_MAX  = {1'b0, {(FILT_W-1){1'b1}}};
  localparam logic signed [FILT_W-1:0]  FILT_MIN  = {1'b1, {(FILT_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;
  localparam logic [Q_W-1:0]            Q_POS_LIM = 17'd32767;
  localparam logic [Q_W-1:0]            Q_NEG_LIM = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 2'd0,
    CFG_INTEG_GAIN     = 2'd1,
    CFG_INTEGRAL_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MF   = 11'b000_0000_0010,
    S_ME   = 11'b000_0000_0100,
    S_FS   = 11'b000_0000_1000,
    S_IS   = 11'b000_0001_0000,
    S_MI   = 11'b000_0010_0000,
    S_AC   = 11'b000_0100_0000,
    S_DS   = 11'b000_1000_0000,
    S_DM   = 11'b001_0000_0000,
    S_DV   = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

endpackage

[design/vpf_in_if.sv]
// ----------------------------------------------------------------------------
// vpf_in_if
// Input channel: operation, wheel counts and motion offset.
// ----------------------------------------------------------------------------
interface vpf_in_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [COUNT_WIDTH-1:0]         left_count;
  logic signed [COUNT_WIDTH-1:0]         right_count;
  logic signed [vpf_pkg::OFFSET_W-1:0]   move_offset;

  modport source (output valid, op, left_count, right_count, move_offset, input ready);
  modport sink   (input valid, op, left_count, right_count, move_offset, output ready);
endinterface

[design/vpf_out_if.sv]
// ----------------------------------------------------------------------------
// vpf_out_if
// Result channel: motor drive and integrator clamp flag.
// ----------------------------------------------------------------------------
interface vpf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpf_pkg::DRIVE_W-1:0]  drive;
  logic                                integral_clamped;

  modport source (output valid, drive, integral_clamped, input ready);
  modport sink   (input valid, drive, integral_clamped, output ready);
endinterface

[design/vpf_mac.sv]
// ----------------------------------------------------------------------------
// vpf_mac
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vpf_mac (
  input  logic                                  clk,
  input  logic signed [vpf_pkg::MAC_A_W-1:0]    op_a,
  input  logic signed [vpf_pkg::MAC_B_W-1:0]    op_b,
  output logic signed [vpf_pkg::MAC_P_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[design/vpf_div.sv]
// ----------------------------------------------------------------------------
// vpf_div
// Drive scaling by 100*65536: latches the sign and the magnitude of the
// accumulator shifted down by 18, capped where the drive saturates anyway,
// and reads the quotient by 25 from its product with a fixed reciprocal.
// ----------------------------------------------------------------------------
module vpf_div (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [vpf_pkg::ACC_W-1:0]    acc,
  input  logic signed [vpf_pkg::MAC_P_W-1:0]  prod,
  output logic [vpf_pkg::X_W-1:0]             xmag_r,
  output logic                                neg_r,
  output logic [vpf_pkg::Q_W-1:0]             quot
);

  logic [vpf_pkg::ACC_W-1:0] mag;
  logic                      cap;

  assign mag = acc[vpf_pkg::ACC_W-1] ? vpf_pkg::ACC_W'(-acc) : vpf_pkg::ACC_W'(acc);
  assign cap = |mag[vpf_pkg::ACC_W-1:vpf_pkg::X_SH+vpf_pkg::X_W];

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r  <= acc[vpf_pkg::ACC_W-1];
      xmag_r <= cap ? '1 : mag[vpf_pkg::X_SH+vpf_pkg::X_W-1:vpf_pkg::X_SH];
    end
  end

  assign quot = prod[vpf_pkg::RECIP_SH+vpf_pkg::Q_W-1:vpf_pkg::RECIP_SH];

endmodule

[design/velocity_pi_with_filter_top.sv]
// ----------------------------------------------------------------------------
// velocity_pi_with_filter_top
// Velocity PI loop with a first-order low-pass filter on the speed error and
// a clamped integrator; one drive value and one clamp flag per item.
// ----------------------------------------------------------------------------
// A run item holds the block from its transfer until the next item can be
// taken: five products go one after another through a single shared 32x22
// multiplier, the last of them scaling by 1/(100*65536) as the accumulator
// magnitude shifted down by 18 times a fixed reciprocal of 25. A clear item
// goes straight to the done state. The result sits in an output register, so
// the next item is taken while an earlier result still waits for its transfer;
// the block then holds its finished result until that register frees.
// ----------------------------------------------------------------------------
`include "velocity_pi_with_filter_top_macros.svh"

module velocity_pi_with_filter_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]      cfg_data,
  vpf_in_if.sink                              in_ch,
  vpf_out_if.source                           out_ch
);

  localparam int ERR_W = COUNT_WIDTH + 2;
  localparam int FS_W  = vpf_pkg::FILT_W + 7;

  vpf_pkg::state_t state_r, state_nxt;

  logic [vpf_pkg::GAIN_W-1:0]          kp_r;
  logic [vpf_pkg::GAIN_W-1:0]          ki_r;
  logic [vpf_pkg::LIMIT_W-1:0]         lim_r;

  logic signed [vpf_pkg::FILT_W-1:0]   f_r;
  logic signed [vpf_pkg::INTEG_W-1:0]  i_r;
  logic signed [ERR_W-1:0]             err_r;
  logic signed [vpf_pkg::OFFSET_W-1:0] off_r;
  logic signed [vpf_pkg::FILT_W-1:0]   t_r;
  logic signed [vpf_pkg::ACC_W-1:0]    acc_r;
  logic                                clamp_r;
  logic signed [vpf_pkg::DRIVE_W-1:0]  res_drive_r;

  logic                                out_valid_r;
  logic signed [vpf_pkg::DRIVE_W-1:0]  out_drive_r;
  logic                                out_clamp_r;

  logic signed [vpf_pkg::MAC_A_W-1:0]  mac_a;
  logic signed [vpf_pkg::MAC_B_W-1:0]  mac_b;
  logic signed [vpf_pkg::MAC_P_W-1:0]  prod;

  logic [vpf_pkg::X_W-1:0]             xmag;
  logic                                acc_neg;
  logic [vpf_pkg::Q_W-1:0]             quot;

  logic                                in_xfer;
  logic                                slot_free;
  logic signed [ERR_W-1:0]             err_in;
  logic signed [FS_W-1:0]              f_sum;
  logic signed [vpf_pkg::FILT_W-1:0]   f_sat;
  logic signed [vpf_pkg::SUM_W-1:0]    s_sum;
  logic signed [vpf_pkg::SUM_W-1:0]    lim_s;
  logic signed [vpf_pkg::INTEG_W-1:0]  lim_ext;
  logic [vpf_pkg::Q_W-1:0]             quot_neg;
  logic signed [vpf_pkg::DRIVE_W-1:0]  drive_val;

  vpf_mac u_mac (
    .clk    (clk),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .prod_r (prod)
  );

  vpf_div u_div (
    .clk    (clk),
    .load   (state_r == vpf_pkg::S_DS),
    .acc    (acc_r),
    .prod   (prod),
    .xmag_r (xmag),
    .neg_r  (acc_neg),
    .quot   (quot)
  );

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == vpf_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive         = out_drive_r;
  assign out_ch.integral_clamped = out_clamp_r;

  assign err_in = -(ERR_W'(in_ch.left_count) + ERR_W'(in_ch.right_count));

  always_comb begin
    mac_a = vpf_pkg::MAC_A_W'(f_r);
    mac_b = vpf_pkg::FILT_KEEP;
    unique case (state_r)
      vpf_pkg::S_ME: begin
        mac_a = vpf_pkg::MAC_A_W'(err_r);
        mac_b = vpf_pkg::ERR_GAIN;
      end
      vpf_pkg::S_IS: begin
        mac_a = vpf_pkg::MAC_A_W'(f_r);
        mac_b = vpf_pkg::MAC_B_W'($signed({1'b0, kp_r}));
      end
      vpf_pkg::S_MI: begin
        mac_a = i_r;
        mac_b = vpf_pkg::MAC_B_W'($signed({1'b0, ki_r}));
      end
      vpf_pkg::S_DM: begin
        mac_a = vpf_pkg::DRIVE_RECIP;
        mac_b = vpf_pkg::MAC_B_W'($signed({1'b0, xmag}));
      end
      default: begin
        mac_a = vpf_pkg::MAC_A_W'(f_r);
        mac_b = vpf_pkg::FILT_KEEP;
      end
    endcase
  end

  assign f_sum = FS_W'(t_r) + FS_W'(prod);
  always_comb begin
    if (f_sum[FS_W-1:vpf_pkg::FILT_W-1] != {(FS_W - vpf_pkg::FILT_W + 1){f_sum[FS_W-1]}}) begin
      f_sat = f_sum[FS_W-1] ? vpf_pkg::FILT_MIN : vpf_pkg::FILT_MAX;
    end else begin
      f_sat = f_sum[vpf_pkg::FILT_W-1:0];
    end
  end

  assign s_sum   = vpf_pkg::SUM_W'(i_r) + vpf_pkg::SUM_W'(f_r)
                 + vpf_pkg::SUM_W'($signed({off_r, 8'h00}));
  assign lim_s   = $signed({{(vpf_pkg::SUM_W - vpf_pkg::LIMIT_W){1'b0}}, lim_r});
  assign lim_ext = $signed({{(vpf_pkg::INTEG_W - vpf_pkg::LIMIT_W){1'b0}}, lim_r});

  assign quot_neg = vpf_pkg::Q_W'(0) - quot;
  always_comb begin
    if (acc_neg) begin
      drive_val = (quot > vpf_pkg::Q_POS_LIM) ?
                  vpf_pkg::DRIVE_MAX : $signed(quot[vpf_pkg::DRIVE_W-1:0]);
    end else begin
      drive_val = (quot > vpf_pkg::Q_NEG_LIM) ?
                  vpf_pkg::DRIVE_MIN : $signed(quot_neg[vpf_pkg::DRIVE_W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vpf_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_ch.op ? vpf_pkg::S_DONE : vpf_pkg::S_MF;
        end
      end
      vpf_pkg::S_MF: state_nxt = vpf_pkg::S_ME;
      vpf_pkg::S_ME: state_nxt = vpf_pkg::S_FS;
      vpf_pkg::S_FS: state_nxt = vpf_pkg::S_IS;
      vpf_pkg::S_IS: state_nxt = vpf_pkg::S_MI;
      vpf_pkg::S_MI: state_nxt = vpf_pkg::S_AC;
      vpf_pkg::S_AC: state_nxt = vpf_pkg::S_DS;
      vpf_pkg::S_DS: state_nxt = vpf_pkg::S_DM;
      vpf_pkg::S_DM: state_nxt = vpf_pkg::S_DV;
      vpf_pkg::S_DV: state_nxt = vpf_pkg::S_DONE;
      vpf_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = vpf_pkg::S_IDLE;
        end
      end
      default: state_nxt = vpf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpf_pkg::S_IDLE;
      kp_r        <= '0;
      ki_r        <= '0;
      lim_r       <= '0;
      f_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (vpf_pkg::cfg_idx_t'(cfg_index))
          vpf_pkg::CFG_PROP_GAIN:      kp_r  <= cfg_data[vpf_pkg::GAIN_W-1:0];
          vpf_pkg::CFG_INTEG_GAIN:     ki_r  <= cfg_data[vpf_pkg::GAIN_W-1:0];
          vpf_pkg::CFG_INTEGRAL_LIMIT: lim_r <= cfg_data[vpf_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (state_r == vpf_pkg::S_IDLE && in_xfer && in_ch.op) begin
        f_r <= '0;
        i_r <= '0;
      end
      if (state_r == vpf_pkg::S_FS) begin
        f_r <= f_sat;
      end
      if (state_r == vpf_pkg::S_IS) begin
        if (s_sum > lim_s) begin
          i_r <= lim_ext;
        end else if (s_sum < -lim_s) begin
          i_r <= -lim_ext;
        end else begin
          i_r <= s_sum[vpf_pkg::INTEG_W-1:0];
        end
      end

      if (state_r == vpf_pkg::S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vpf_pkg::S_IDLE && in_xfer) begin
      err_r       <= err_in;
      off_r       <= in_ch.move_offset;
      clamp_r     <= 1'b0;
      res_drive_r <= '0;
    end
    if (state_r == vpf_pkg::S_ME) begin
      t_r <= prod[vpf_pkg::FILT_W+7:8];
    end
    if (state_r == vpf_pkg::S_IS) begin
      clamp_r <= (s_sum > lim_s) || (s_sum < -lim_s);
    end
    if (state_r == vpf_pkg::S_MI) begin
      acc_r <= vpf_pkg::ACC_W'(prod);
    end
    if (state_r == vpf_pkg::S_AC) begin
      acc_r <= acc_r + vpf_pkg::ACC_W'(prod);
    end
    if (state_r == vpf_pkg::S_DV) begin
      res_drive_r <= drive_val;
    end
    if (state_r == vpf_pkg::S_DONE && slot_free) begin
      out_drive_r <= res_drive_r;
      out_clamp_r <= clamp_r;
    end
  end

  `VPF_ASSERT_NXT(a_clamp_at_limit, clk, rst_n, state_r == vpf_pkg::S_IS,
                  !clamp_r || i_r == lim_ext || i_r == -lim_ext)
  `VPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready,
                  out_valid_r && $stable(out_drive_r) && $stable(out_clamp_r))
  `VPF_ASSERT_NXT(a_clear_goes_done, clk, rst_n, in_xfer && in_ch.op,
                  state_r == vpf_pkg::S_DONE && res_drive_r == '0 && !clamp_r)
  `VPF_ASSERT_NXT(a_result_loaded, clk, rst_n, state_r == vpf_pkg::S_DONE && slot_free,
                  out_valid_r && state_r == vpf_pkg::S_IDLE)

endmodule

[tb/sv/vpf_tb_pkg.sv]
// ----------------------------------------------------------------------------
// vpf_tb_pkg
// Operation codes and the result record shared by the velocity PI testbench.
// ----------------------------------------------------------------------------
package vpf_tb_pkg;

  typedef enum logic {
    OP_RUN   = 1'b0,
    OP_CLEAR = 1'b1
  } vpf_op_t;

  typedef struct packed {
    logic signed [vpf_pkg::DRIVE_W-1:0] drive;
    logic                               clamped;
  } drive_result_t;

endpackage

[tb/sv/drive_scoreboard.sv]
// ----------------------------------------------------------------------------
// drive_scoreboard
// Watches the register port and both channels of the velocity PI loop, keeps
// its own filter, integrator and gain copies, predicts the drive and clamp
// flag of every transfer taken in, and compares each result transfer with
// the oldest prediction.
// ----------------------------------------------------------------------------
module drive_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0] cfg_data,
  vpf_in_if                             in_mon,
  vpf_out_if                            out_mon,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import vpf_pkg::*;
  import vpf_tb_pkg::*;

  localparam longint DRIVE_DIVISOR = 64'sd6553600;
  localparam longint FILT_HI       = (64'sd1 <<< (FILT_W - 1)) - 1;
  localparam longint FILT_LO       = -(64'sd1 <<< (FILT_W - 1));

  logic [GAIN_W-1:0]         kp_q;
  logic [GAIN_W-1:0]         ki_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic signed [FILT_W-1:0]  filt_q;
  logic signed [INTEG_W-1:0] integ_q;
  drive_result_t             drive_expect_q[$];
  int unsigned               results_seen;

  function automatic drive_result_t predict_drive(input vpf_op_t op, input longint left,
                                                   input longint right, input longint offset);
    drive_result_t res;
    longint        err;
    longint        f;
    longint        s;
    longint        lim;
    longint        acc;
    longint        d;
    res.drive   = '0;
    res.clamped = 1'b0;
    if (op == OP_CLEAR) begin
      filt_q  = '0;
      integ_q = '0;
      return res;
    end
    err = -(left + right);
    f = ((64'sd215 * longint'(filt_q)) >>> 8) + 64'sd41 * err;
    if (f > FILT_HI) f = FILT_HI;
    if (f < FILT_LO) f = FILT_LO;
    filt_q = FILT_W'(f);
    lim = longint'(limit_q);
    s = longint'(integ_q) + f + offset * 256;
    if (s > lim) begin
      s = lim;
      res.clamped = 1'b1;
    end
    if (s < -lim) begin
      s = -lim;
      res.clamped = 1'b1;
    end
    integ_q = INTEG_W'(s);
    acc = f * longint'(kp_q) + s * longint'(ki_q);
    d = -(acc / DRIVE_DIVISOR);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    res.drive = DRIVE_W'(d);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("%0t ns: result %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      kp_q          = '0;
      ki_q          = '0;
      limit_q       = '0;
      filt_q        = '0;
      integ_q       = '0;
      fail_count    = 0;
      results_seen  = 0;
      drive_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROP_GAIN:      kp_q    = cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN:     ki_q    = cfg_data[GAIN_W-1:0];
          CFG_INTEGRAL_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        drive_expect_q.push_back(predict_drive(vpf_op_t'(in_mon.op),
                                               longint'(in_mon.left_count),
                                               longint'(in_mon.right_count),
                                               longint'(in_mon.move_offset)));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected transfer, drive", longint'(out_mon.drive), 0);
        end else begin
          want = drive_expect_q.pop_front();
          if (out_mon.drive !== want.drive) begin
            report_mismatch("drive", longint'(out_mon.drive), longint'(want.drive));
          end
          if (out_mon.integral_clamped !== want.clamped) begin
            report_mismatch("integral_clamped", longint'(out_mon.integral_clamped),
                            longint'(want.clamped));
          end
        end
        results_seen++;
      end
    end
    pending_count = drive_expect_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the velocity PI loop through directed corner items and random
// control sequences under several gain and limit settings, with random
// idling on both channels and two long result stalls; the scoreboard beside
// the block predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vpf_pkg::*;
  import vpf_tb_pkg::*;

  localparam int HOLD_LEN   = 400;
  localparam int SETTLE_LEN = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_total;
  int pending_total;

  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int hold_asks   = 0;

  vpf_in_if #(.COUNT_WIDTH(16)) in_ch();
  vpf_out_if                    out_ch();

  velocity_pi_with_filter_top #(.COUNT_WIDTH(16)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  drive_scoreboard scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (mismatch_total),
    .pending_count (pending_total)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random idling plus long holds on request
  initial begin
    int hold_left;
    int hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (out_gaps_on && $urandom_range(99) < 15) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_total != 0) @(negedge clk);
    repeat (SETTLE_LEN) @(negedge clk);
  endtask

  task automatic set_gains(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                           input logic [CFG_DATA_W-1:0] lim);
    drain_results();
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_INTEGRAL_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input vpf_op_t op, input logic signed [15:0] left,
                           input logic signed [15:0] right, input logic signed [15:0] offset);
    if (in_gaps_on) begin
      while ($urandom_range(99) < 15) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.left_count  <= left;
    in_ch.right_count <= right;
    in_ch.move_offset <= offset;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_value(input int spread);
    if ($urandom_range(9) < 2) return 16'($urandom);
    return 16'($urandom_range(2 * spread)) - 16'(spread);
  endfunction

  task automatic run_random(input int count, input bit with_hold);
    vpf_op_t op;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 4) hold_asks++;
      op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_RUN;
      send_item(op, pick_value(300), pick_value(300), pick_value(40));
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_RUN;
    in_ch.left_count  = '0;
    in_ch.right_count = '0;
    in_ch.move_offset = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes of every field with the largest gains and limit
    set_gains(28'hFFFF, 28'hFFFF, 28'hFFFFFFF);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_RUN, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(OP_RUN, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OP_RUN, 16'sd32767, -16'sd32768, 16'sd0);
    send_item(OP_RUN, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_CLEAR, -16'sd1, -16'sd1, -16'sd1);
    send_item(OP_RUN, -16'sd32768, 16'sd32767, -16'sd32768);

    // zero limit holds the integrator at zero
    set_gains(28'd256, 28'd256, 28'd0);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_RUN, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_RUN, 16'sd5, 16'sd7, 16'sd0);
    send_item(OP_RUN, 16'sd0, 16'sd0, 16'sd3);

    // integrator landing exactly on the limit, then past it
    set_gains(28'd512, 28'd256, 28'd256);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_RUN, 16'sd0, 16'sd0, 16'sd1);
    send_item(OP_RUN, 16'sd0, 16'sd0, 16'sd1);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_RUN, 16'sd0, 16'sd0, -16'sd1);
    send_item(OP_RUN, 16'sd0, 16'sd0, -16'sd1);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);

    set_gains(28'd0, 28'd1, 28'd1);
    send_item(OP_RUN, 16'sd100, 16'sd100, 16'sd0);

    set_gains(28'd10240, 28'd128, 28'd512000);
    run_random(215, 1'b0);

    set_gains(28'($urandom), 28'($urandom), 28'($urandom));
    run_random(215, 1'b1);

    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_gains(28'd0, 28'd0, 28'hFFFFFFF);
    run_random(215, 1'b0);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;

    set_gains(28'hFFFF, 28'd0, 28'd0);
    run_random(215, 1'b0);

    set_gains(28'd0, 28'hFFFF, 28'd1000);
    run_random(215, 1'b1);

    set_gains(28'd2560, 28'd512, 28'd12800);
    run_random(215, 1'b0);

    drain_results();
    if (mismatch_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/vpf_pkg.sv
design/vpf_in_if.sv
design/vpf_out_if.sv
design/vpf_mac.sv
design/vpf_div.sv
design/velocity_pi_with_filter_top.sv
tb/sv/vpf_tb_pkg.sv
tb/sv/drive_scoreboard.sv
tb/sv/testbench.sv
